[rtl/core/fsbme_pkg.sv]
package fsbme_pkg;

    localparam int MAX_WIDTH    = 512;
    localparam int MAX_HEIGHT   = 512;
    localparam int MAX_REFS     = 4;
    localparam int SEARCH_RANGE = 16;
    localparam int MAX_BLOCK    = 16;
    localparam int SLOTS        = MAX_REFS + 1;

    localparam int SLOT_W  = 3;
    localparam int ROW_W   = 9;
    localparam int COL_W   = 9;
    localparam int PIX_W   = 8;
    localparam int DIM_W   = 10;
    localparam int BLK_W   = 5;
    localparam int REFS_W  = 3;
    localparam int UV_W    = 4;
    localparam int SCORE_W = 16;
    localparam int OFF_W   = 5;
    localparam int ADDR_W  = SLOT_W + ROW_W + COL_W;
    localparam int STORE_DEPTH = SLOTS * MAX_HEIGHT * MAX_WIDTH;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_COUNT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALL_REFS     = 3'd4;

    localparam logic MODE_PIXEL  = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0]  frame_width;
        logic [DIM_W-1:0]  frame_height;
        logic [BLK_W-1:0]  block_size;
        logic [REFS_W-1:0] ref_count;
        logic              all_refs_mode;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } t_request;

    typedef struct packed {
        logic [REFS_W-1:0]       ref_distance;
        logic signed [OFF_W-1:0] row_offset;
        logic signed [OFF_W-1:0] col_offset;
        logic                    last;
    } t_result;

endpackage

[rtl/core/fsbme_store.sv]
module fsbme_store (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [fsbme_pkg::ADDR_W-1:0]  i_waddr,
    input  logic [fsbme_pkg::PIX_W-1:0]   i_wdata,
    input  logic [fsbme_pkg::ADDR_W-1:0]  i_raddr_a,
    input  logic [fsbme_pkg::ADDR_W-1:0]  i_raddr_b,
    output logic [fsbme_pkg::PIX_W-1:0]   o_rdata_a,
    output logic [fsbme_pkg::PIX_W-1:0]   o_rdata_b
);

    logic [fsbme_pkg::PIX_W-1:0] r_mem [fsbme_pkg::STORE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

[rtl/core/fsbme_search.sv]
module fsbme_search (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fsbme_pkg::t_cfg               i_cfg,
    input  fsbme_pkg::t_request           i_req,
    output logic                          o_idle,
    output logic [fsbme_pkg::ADDR_W-1:0]  o_cur_addr,
    output logic [fsbme_pkg::ADDR_W-1:0]  o_ref_addr,
    input  logic [fsbme_pkg::PIX_W-1:0]   i_cur_pix,
    input  logic [fsbme_pkg::PIX_W-1:0]   i_ref_pix,
    output logic                          o_res_valid,
    output fsbme_pkg::t_result            o_res,
    input  logic                          i_res_ready
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SETUP  = 3'd1;
    localparam logic [2:0] ST_ISSUE  = 3'd2;
    localparam logic [2:0] ST_WAIT   = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    localparam int EXT_W = fsbme_pkg::DIM_W + 1;

    logic [2:0] r_state, n_state;

    logic [fsbme_pkg::DIM_W-1:0]   r_w, r_h;
    logic [fsbme_pkg::BLK_W-1:0]   r_n;
    logic [fsbme_pkg::REFS_W-1:0]  r_refs, r_d;
    logic                          r_all, r_reject;
    logic [fsbme_pkg::SLOT_W-1:0]  r_slot, r_rslot;
    logic [fsbme_pkg::ROW_W-1:0]   r_row, r_x;
    logic [fsbme_pkg::COL_W-1:0]   r_col, r_y;
    logic [fsbme_pkg::UV_W-1:0]    r_u, r_v;

    logic                          r_p1_valid, r_p1_first, r_p1_last;
    logic [fsbme_pkg::ROW_W-1:0]   r_p1_x;
    logic [fsbme_pkg::COL_W-1:0]   r_p1_y;

    logic [fsbme_pkg::SCORE_W-1:0] r_acc, r_best_score;
    logic [fsbme_pkg::ROW_W-1:0]   r_best_row;
    logic [fsbme_pkg::COL_W-1:0]   r_best_col;
    logic [fsbme_pkg::REFS_W-1:0]  r_best_dist;

    logic [fsbme_pkg::DIM_W-1:0]   w_clip, h_clip;
    logic [fsbme_pkg::REFS_W-1:0]  refs_clip;
    logic                          reject;
    logic [3:0]                    slot_sum;
    logic [fsbme_pkg::ROW_W-1:0]   x0;
    logic [fsbme_pkg::COL_W-1:0]   y0;
    logic [fsbme_pkg::UV_W-1:0]    n_last;
    logic                          uv_first, v_end, cand_last, x_ok, y_ok;
    logic [EXT_W-1:0]              y_reach, x_reach;
    logic [fsbme_pkg::PIX_W-1:0]   diff;
    logic [fsbme_pkg::SCORE_W-1:0] sum;
    logic [fsbme_pkg::ROW_W-1:0]   row_delta;
    logic [fsbme_pkg::COL_W-1:0]   col_delta;

    always_comb begin
        w_clip = (i_cfg.frame_width > fsbme_pkg::DIM_W'(fsbme_pkg::MAX_WIDTH))
               ? fsbme_pkg::DIM_W'(fsbme_pkg::MAX_WIDTH) : i_cfg.frame_width;
        h_clip = (i_cfg.frame_height > fsbme_pkg::DIM_W'(fsbme_pkg::MAX_HEIGHT))
               ? fsbme_pkg::DIM_W'(fsbme_pkg::MAX_HEIGHT) : i_cfg.frame_height;
        refs_clip = (i_cfg.ref_count > fsbme_pkg::REFS_W'(fsbme_pkg::MAX_REFS))
                  ? fsbme_pkg::REFS_W'(fsbme_pkg::MAX_REFS) : i_cfg.ref_count;
        reject = ({1'b0, i_req.slot} >= 4'(fsbme_pkg::SLOTS))
              || (i_cfg.block_size == '0)
              || (i_cfg.block_size > fsbme_pkg::BLK_W'(fsbme_pkg::MAX_BLOCK))
              || (refs_clip == '0)
              || ((EXT_W'(i_req.row) + EXT_W'(i_cfg.block_size)) > EXT_W'(h_clip))
              || ((EXT_W'(i_req.col) + EXT_W'(i_cfg.block_size)) > EXT_W'(w_clip));

        slot_sum = {1'b0, r_slot} + 4'(fsbme_pkg::SLOTS) - {1'b0, r_d};
        x0 = (r_row >= fsbme_pkg::ROW_W'(fsbme_pkg::SEARCH_RANGE))
           ? r_row - fsbme_pkg::ROW_W'(fsbme_pkg::SEARCH_RANGE) : '0;
        y0 = (r_col >= fsbme_pkg::COL_W'(fsbme_pkg::SEARCH_RANGE))
           ? r_col - fsbme_pkg::COL_W'(fsbme_pkg::SEARCH_RANGE) : '0;

        n_last    = fsbme_pkg::UV_W'(r_n - 5'd1);
        uv_first  = (r_u == '0) && (r_v == '0);
        v_end     = (r_v == n_last);
        cand_last = v_end && (r_u == n_last);
        y_reach   = EXT_W'(r_y) + EXT_W'(1) + EXT_W'(r_n);
        x_reach   = EXT_W'(r_x) + EXT_W'(1) + EXT_W'(r_n);
        y_ok = (y_reach <= EXT_W'(r_w))
            && (y_reach <= EXT_W'(r_col) + EXT_W'(fsbme_pkg::SEARCH_RANGE));
        x_ok = (x_reach <= EXT_W'(r_h))
            && (x_reach <= EXT_W'(r_row) + EXT_W'(fsbme_pkg::SEARCH_RANGE));

        o_cur_addr = {r_slot, r_row + fsbme_pkg::ROW_W'(r_u), r_col + fsbme_pkg::COL_W'(r_v)};
        o_ref_addr = {r_rslot, r_x + fsbme_pkg::ROW_W'(r_u), r_y + fsbme_pkg::COL_W'(r_v)};

        diff = (i_cur_pix > i_ref_pix) ? i_cur_pix - i_ref_pix : i_ref_pix - i_cur_pix;
        sum  = (r_p1_first ? '0 : r_acc) + fsbme_pkg::SCORE_W'(diff);

        row_delta = r_best_row - r_row;
        col_delta = r_best_col - r_col;
        o_idle      = (r_state == ST_IDLE);
        o_res_valid = (r_state == ST_RESULT);
        if (r_reject) begin
            o_res.ref_distance = '0;
            o_res.row_offset   = '0;
            o_res.col_offset   = '0;
            o_res.last         = 1'b1;
        end else begin
            o_res.ref_distance = r_best_dist;
            o_res.row_offset   = row_delta[fsbme_pkg::OFF_W-1:0];
            o_res.col_offset   = col_delta[fsbme_pkg::OFF_W-1:0];
            o_res.last         = !r_all || (r_d == r_refs);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = reject ? ST_RESULT : ST_SETUP;
                end
            end
            ST_SETUP: n_state = ST_ISSUE;
            ST_ISSUE: begin
                if (cand_last && !y_ok && !x_ok) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (r_all || (r_d == r_refs)) begin
                    n_state = ST_RESULT;
                end else begin
                    n_state = ST_SETUP;
                end
            end
            ST_RESULT: begin
                if (i_res_ready) begin
                    if (!r_reject && r_all && (r_d != r_refs)) begin
                        n_state = ST_SETUP;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_p1_valid   <= 1'b0;
            r_best_score <= '1;
            r_best_row   <= '0;
            r_best_col   <= '0;
            r_best_dist  <= '0;
        end else begin
            r_state    <= n_state;
            r_p1_valid <= (r_state == ST_ISSUE);

            if (r_state == ST_SETUP && (r_all || r_d == fsbme_pkg::REFS_W'(1))) begin
                r_best_score <= '1;
            end else if (r_p1_valid && r_p1_last && (sum < r_best_score)) begin
                r_best_score <= sum;
                r_best_row   <= r_p1_x;
                r_best_col   <= r_p1_y;
                r_best_dist  <= r_d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_first <= uv_first;
        r_p1_last  <= cand_last;
        r_p1_x     <= r_x;
        r_p1_y     <= r_y;
        if (r_p1_valid) begin
            r_acc <= sum;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    r_w      <= w_clip;
                    r_h      <= h_clip;
                    r_n      <= i_cfg.block_size;
                    r_refs   <= refs_clip;
                    r_all    <= i_cfg.all_refs_mode;
                    r_reject <= reject;
                    r_slot   <= i_req.slot;
                    r_row    <= i_req.row;
                    r_col    <= i_req.col;
                    r_d      <= fsbme_pkg::REFS_W'(1);
                end
            end
            ST_SETUP: begin
                r_rslot <= (slot_sum >= 4'(fsbme_pkg::SLOTS))
                         ? fsbme_pkg::SLOT_W'(slot_sum - 4'(fsbme_pkg::SLOTS))
                         : fsbme_pkg::SLOT_W'(slot_sum);
                r_x <= x0;
                r_y <= y0;
                r_u <= '0;
                r_v <= '0;
            end
            ST_ISSUE: begin
                if (!v_end) begin
                    r_v <= r_v + 1'b1;
                end else if (!cand_last) begin
                    r_v <= '0;
                    r_u <= r_u + 1'b1;
                end else begin
                    r_v <= '0;
                    r_u <= '0;
                    if (y_ok) begin
                        r_y <= r_y + 1'b1;
                    end else if (x_ok) begin
                        r_y <= y0;
                        r_x <= r_x + 1'b1;
                    end
                end
            end
            ST_WAIT: begin
                if (!r_all && (r_d != r_refs)) begin
                    r_d <= r_d + 1'b1;
                end
            end
            ST_RESULT: begin
                if (i_res_ready && !r_reject && r_all && (r_d != r_refs)) begin
                    r_d <= r_d + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[rtl/core/full_search_block_motion_estimation.sv]
// Full-search block-matching motion estimator scored by sum of absolute differences.
// Input beats on the s_axis group carry either a pixel write (tuser 0) into one of
// five frame slots, or a search request (tuser 1) naming the current frame's slot
// and the top-left corner of a block. Pixel writes give no output beat.
// A search scans ref_count previous slots and emits one motion vector on the
// m_axis group, or one per reference when all_refs_mode is set; tlast marks the
// final beat of a request. A rejected request gives a single beat with distance 0.
// For each reference the search scores every position of the clipped window (up to
// 32 by 32 positions) with an n by n block, where n is the block size; the frame
// memory's two read ports deliver one current and one reference pixel per cycle
// while a window is scanned.
// The block accepts one beat at a time: s_tready is low while a search runs and
// while its result waits for a free output register. A stalled receiver holds the
// output register and, behind it, the search. Reset is synchronous and active low;
// it restores the configuration defaults and empties the output register, while
// the frame memory holds its contents and must be written before being searched.
// Configuration writes are taken at once; they belong to an idle block, since a
// search latches the registers when it starts.
module full_search_block_motion_estimation (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fsbme_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fsbme_pkg::DIM_W-1:0]        i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // frame_slot[2:0], row[11:3], col[20:12], pixel[28:21], zero fill above
    input  logic [31:0]                        s_axis_tdata,
    // mode[0]
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // ref_distance[2:0], row_offset[7:3], col_offset[12:8], zero fill above
    output logic [15:0]                        m_axis_tdata,
    output logic                               m_axis_tlast
);

    fsbme_pkg::t_cfg     r_cfg;
    fsbme_pkg::t_request req;
    fsbme_pkg::t_result  res, r_out;
    logic                r_out_valid;

    logic                              idle, in_acc, we;
    logic [fsbme_pkg::SLOT_W-1:0]      in_slot;
    logic [fsbme_pkg::ROW_W-1:0]       in_row;
    logic [fsbme_pkg::COL_W-1:0]       in_col;
    logic [fsbme_pkg::PIX_W-1:0]       in_pix;
    logic [fsbme_pkg::ADDR_W-1:0]      cur_addr, ref_addr;
    logic [fsbme_pkg::PIX_W-1:0]       cur_pix, ref_pix;
    logic                              res_valid, res_ready;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = idle;
    assign in_acc        = s_axis_tvalid && idle;
    assign in_slot       = s_axis_tdata[2:0];
    assign in_row        = s_axis_tdata[11:3];
    assign in_col        = s_axis_tdata[20:12];
    assign in_pix        = s_axis_tdata[28:21];
    assign we = in_acc && (s_axis_tuser == fsbme_pkg::MODE_PIXEL)
             && ({1'b0, in_slot} < 4'(fsbme_pkg::SLOTS));

    assign req.valid = in_acc && (s_axis_tuser == fsbme_pkg::MODE_SEARCH);
    assign req.slot  = in_slot;
    assign req.row   = in_row;
    assign req.col   = in_col;

    assign res_ready     = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.col_offset, r_out.row_offset, r_out.ref_distance};
    assign m_axis_tlast  = r_out.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width   <= fsbme_pkg::DIM_W'(352);
            r_cfg.frame_height  <= fsbme_pkg::DIM_W'(288);
            r_cfg.block_size    <= fsbme_pkg::BLK_W'(8);
            r_cfg.ref_count     <= fsbme_pkg::REFS_W'(1);
            r_cfg.all_refs_mode <= 1'b0;
            r_out_valid         <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    fsbme_pkg::CFG_FRAME_WIDTH:  r_cfg.frame_width  <= i_cfg_data;
                    fsbme_pkg::CFG_FRAME_HEIGHT: r_cfg.frame_height <= i_cfg_data;
                    fsbme_pkg::CFG_BLOCK_SIZE:
                        r_cfg.block_size <= i_cfg_data[fsbme_pkg::BLK_W-1:0];
                    fsbme_pkg::CFG_REF_COUNT:
                        r_cfg.ref_count <= i_cfg_data[fsbme_pkg::REFS_W-1:0];
                    fsbme_pkg::CFG_ALL_REFS:     r_cfg.all_refs_mode <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (res_valid && res_ready) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    fsbme_store u_store (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   ({in_slot, in_row, in_col}),
        .i_wdata   (in_pix),
        .i_raddr_a (cur_addr),
        .i_raddr_b (ref_addr),
        .o_rdata_a (cur_pix),
        .o_rdata_b (ref_pix)
    );

    fsbme_search u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_req       (req),
        .o_idle      (idle),
        .o_cur_addr  (cur_addr),
        .o_ref_addr  (ref_addr),
        .i_cur_pix   (cur_pix),
        .i_ref_pix   (ref_pix),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import fsbme_pkg::*;

    localparam int CYCLE_LIMIT = 8000000;
    localparam int HOLD_CYCLES = 3000;
    localparam int NO_SCORE    = 32'h7fffffff;

    typedef struct {
        bit       mode;
        bit [2:0] slot;
        bit [8:0] row;
        bit [8:0] col;
        bit [7:0] pix;
    } t_luma_beat;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DIM_W-1:0]     i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [15:0]          m_axis_tdata;
    logic                 m_axis_tlast;

    full_search_block_motion_estimation u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    t_luma_beat beat_q[$];
    t_luma_beat next_beat;
    t_result    vector_q[$];
    bit [7:0]   luma_store[int];
    bit         planned[int];

    int  cur_width = 352, cur_height = 288, cur_block = 8, cur_refs = 1;
    bit  cur_all_refs = 0;
    int  best_sad, best_x, best_y, best_dist;
    int  cycle_count = 0;
    int  error_count = 0;
    int  search_count = 0;
    int  vector_count = 0;
    bit  in_taken = 0;
    bit  cfg_taken = 0;
    bit  hold_request = 0;
    bit  hold_done = 0;
    int  hold_left = 0;
    bit  quiet;

    assign quiet = (cycle_count % 60000) < 12000;

    initial i_clk = 0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int luma_addr(int slot, int row, int col);
        return slot * MAX_HEIGHT * MAX_WIDTH + row * MAX_WIDTH + col;
    endfunction

    function automatic int luma_at(int slot, int row, int col);
        int a;
        a = luma_addr(slot, row, col);
        return luma_store.exists(a) ? int'(luma_store[a]) : 0;
    endfunction

    function automatic bit request_rejected(int slot, int row, int col);
        int w, h, r;
        w = cur_width > MAX_WIDTH ? MAX_WIDTH : cur_width;
        h = cur_height > MAX_HEIGHT ? MAX_HEIGHT : cur_height;
        r = cur_refs > MAX_REFS ? MAX_REFS : cur_refs;
        return slot >= SLOTS || cur_block == 0 || cur_block > MAX_BLOCK || r == 0 ||
               row + cur_block > h || col + cur_block > w;
    endfunction

    function automatic void push_vector(int row, int col, bit last);
        t_result v;
        v.ref_distance = best_dist[2:0];
        v.row_offset   = 5'(best_x - row);
        v.col_offset   = 5'(best_y - col);
        v.last         = last;
        vector_q = {vector_q, v};
    endfunction

    function automatic void predict_search(int slot, int row, int col);
        int w, h, n, r, rs, x0, y0, sad, a, b;
        t_result v;
        w = cur_width > MAX_WIDTH ? MAX_WIDTH : cur_width;
        h = cur_height > MAX_HEIGHT ? MAX_HEIGHT : cur_height;
        r = cur_refs > MAX_REFS ? MAX_REFS : cur_refs;
        n = cur_block;
        if (request_rejected(slot, row, col)) begin
            v = '{ref_distance: '0, row_offset: '0, col_offset: '0, last: 1'b1};
            vector_q = {vector_q, v};
            return;
        end
        best_sad = NO_SCORE;
        x0 = row >= SEARCH_RANGE ? row - SEARCH_RANGE : 0;
        y0 = col >= SEARCH_RANGE ? col - SEARCH_RANGE : 0;
        for (int d = 1; d <= r; d++) begin
            if (cur_all_refs) best_sad = NO_SCORE;
            rs = (slot + SLOTS - d) % SLOTS;
            for (int x = x0; x + n <= h && x + n <= row + SEARCH_RANGE; x++) begin
                for (int y = y0; y + n <= w && y + n <= col + SEARCH_RANGE; y++) begin
                    sad = 0;
                    for (int u = 0; u < n; u++) begin
                        for (int k = 0; k < n; k++) begin
                            a = luma_at(slot, row + u, col + k);
                            b = luma_at(rs, x + u, y + k);
                            sad += a > b ? a - b : b - a;
                        end
                    end
                    if (sad < best_sad) begin
                        best_sad = sad;
                        best_x = x;
                        best_y = y;
                        best_dist = d;
                    end
                end
            end
            if (cur_all_refs) push_vector(row, col, d == r);
        end
        if (!cur_all_refs) push_vector(row, col, 1'b1);
    endfunction

    // Input side: beat acceptance, configuration acceptance and the prediction.
    always @(posedge i_clk) begin
        in_taken  <= s_axis_tvalid && s_axis_tready;
        cfg_taken <= i_cfg_valid && o_cfg_ready;
        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  cur_width    = i_cfg_data;
                CFG_FRAME_HEIGHT: cur_height   = i_cfg_data;
                CFG_BLOCK_SIZE:   cur_block    = i_cfg_data[BLK_W-1:0];
                CFG_REF_COUNT:    cur_refs     = i_cfg_data[REFS_W-1:0];
                CFG_ALL_REFS:     cur_all_refs = i_cfg_data[0];
                default: ;
            endcase
        end
        if (s_axis_tvalid && s_axis_tready) begin
            if (s_axis_tuser == MODE_PIXEL) begin
                if (s_axis_tdata[2:0] < SLOTS)
                    luma_store[luma_addr(s_axis_tdata[2:0], s_axis_tdata[11:3],
                                         s_axis_tdata[20:12])] = s_axis_tdata[28:21];
            end else begin
                search_count++;
                predict_search(s_axis_tdata[2:0], s_axis_tdata[11:3], s_axis_tdata[20:12]);
            end
        end
    end

    // Output side: every vector beat is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_result exp_v;
        if (m_axis_tvalid && m_axis_tready) begin
            vector_count++;
            if (vector_q.size() == 0) begin
                $error("unexpected vector beat %h last %b", m_axis_tdata, m_axis_tlast);
                error_count++;
            end else begin
                exp_v = vector_q.pop_front();
                if (m_axis_tdata[2:0] !== exp_v.ref_distance) begin
                    $error("ref_distance expected %0d got %0d", exp_v.ref_distance,
                           m_axis_tdata[2:0]);
                    error_count++;
                end
                if (m_axis_tdata[7:3] !== exp_v.row_offset) begin
                    $error("row_offset expected %0d got %0d", exp_v.row_offset,
                           $signed(m_axis_tdata[7:3]));
                    error_count++;
                end
                if (m_axis_tdata[12:8] !== exp_v.col_offset) begin
                    $error("col_offset expected %0d got %0d", exp_v.col_offset,
                           $signed(m_axis_tdata[12:8]));
                    error_count++;
                end
                if (m_axis_tlast !== exp_v.last) begin
                    $error("last expected %0d got %0d", exp_v.last, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (beat_q.size() > 0 && (quiet || $urandom_range(99) >= 14)) begin
                next_beat = beat_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= next_beat.mode;
                s_axis_tdata  <= {3'b0, next_beat.pix, next_beat.col, next_beat.row,
                                  next_beat.slot};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_request && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= quiet || $urandom_range(99) >= 14;
        end
    end

    task automatic add_pixel(int slot, int row, int col, int val);
        t_luma_beat b;
        b = '{mode: MODE_PIXEL, slot: slot, row: row, col: col, pix: val};
        beat_q = {beat_q, b};
        if (slot < SLOTS) planned[luma_addr(slot, row, col)] = 1'b1;
    endtask

    task automatic fill_area(int slot, int r0, int r1, int c0, int c1);
        for (int r = r0; r <= r1; r++)
            for (int c = c0; c <= c1; c++)
                if (!planned.exists(luma_addr(slot, r, c)))
                    add_pixel(slot, r, c, $urandom_range(255));
    endtask

    // Every pixel that the search may read is written before the request goes out.
    task automatic add_search(int slot, int row, int col);
        t_luma_beat b;
        int w, h, r, n;
        w = cur_width > MAX_WIDTH ? MAX_WIDTH : cur_width;
        h = cur_height > MAX_HEIGHT ? MAX_HEIGHT : cur_height;
        r = cur_refs > MAX_REFS ? MAX_REFS : cur_refs;
        n = cur_block;
        if (!request_rejected(slot, row, col)) begin
            fill_area(slot, row, row + n - 1, col, col + n - 1);
            for (int d = 1; d <= r; d++)
                fill_area((slot + SLOTS - d) % SLOTS,
                          row >= SEARCH_RANGE ? row - SEARCH_RANGE : 0,
                          (h < row + SEARCH_RANGE ? h : row + SEARCH_RANGE) - 1,
                          col >= SEARCH_RANGE ? col - SEARCH_RANGE : 0,
                          (w < col + SEARCH_RANGE ? w : col + SEARCH_RANGE) - 1);
        end
        b = '{mode: MODE_SEARCH, slot: slot, row: row, col: col, pix: $urandom_range(255)};
        beat_q = {beat_q, b};
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (beat_q.size() > 0 || s_axis_tvalid || vector_q.size() > 0);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[DIM_W-1:0];
        do @(negedge i_clk);
        while (!cfg_taken);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(int w, int h, int n, int r, int all);
        wait_idle();
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_BLOCK_SIZE, n);
        write_reg(CFG_REF_COUNT, r);
        write_reg(CFG_ALL_REFS, all);
        @(negedge i_clk);
    endtask

    initial begin
        int w, h, n;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, starting from the reset configuration.
        add_pixel(7, 511, 511, 255);
        add_pixel(4, 511, 511, 0);
        add_search(5, 0, 0);
        add_search(7, 0, 0);
        add_search(0, 281, 0);
        add_search(0, 0, 345);
        configure(512, 512, 16, 1, 0);
        add_search(1, 497, 0);
        configure(1023, 600, 2, 7, 1);
        add_search(2, 511, 0);
        add_search(3, 0, 511);
        configure(1, 1, 1, 4, 1);
        add_search(4, 0, 0);
        add_search(4, 1, 0);
        configure(8, 8, 0, 2, 0);
        add_search(0, 0, 0);
        configure(8, 8, 17, 2, 0);
        add_search(0, 0, 0);
        configure(8, 8, 31, 0, 0);
        add_search(0, 0, 0);
        configure(8, 8, 2, 0, 1);
        add_search(0, 0, 0);

        // Random part: mostly well-formed searches in tiny frames.
        for (int p = 0; p < 6; p++) begin
            configure($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 2),
                      $urandom_range(0, 7), $urandom_range(1));
            if (p == 2) hold_request = 1'b1;
            w = cur_width;
            h = cur_height;
            n = cur_block;
            for (int k = 0; k < 4; k++) begin
                repeat ($urandom_range(1))
                    add_pixel($urandom_range(7), $urandom_range(h - 1),
                              $urandom_range(w - 1), $urandom_range(255));
                if ($urandom_range(99) < 80 && n <= w && n <= h)
                    add_search($urandom_range(4), $urandom_range(h - n), $urandom_range(w - n));
                else
                    add_search($urandom_range(7), $urandom_range(h), $urandom_range(w));
            end
        end

        wait_idle();
        $display("Ran %0d searches with %0d vector beats over %0d cycles.",
                 search_count, vector_count, cycle_count);
        $display("Covered size clipping, rejected requests, both result modes and a long stall.");
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
